// ===== rtl/core/bra_pkg.sv =====
// Shared types and constants for the bitmap run allocator.
// Used by bra_map, bra_scan and bitmap_run_allocator_unit; depends on nothing.
package bra_pkg;

  // Default map size and the digit that the map hands out each cycle while it shifts
  localparam int MAP_BITS_DEF = 256;
  localparam int DIGIT_BITS   = 8;
  localparam int DIGIT_LOG    = 3;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_FIND  = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // Largest run length the result field can carry
  localparam logic [8:0] RUN_LEN_MAX = 9'h1ff;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] start_index;
    logic [8:0] run_count;
    logic       find_value;
  } req_t;

  typedef struct packed {
    logic       success;
    logic [7:0] bit_index;
    logic [8:0] run_length;
  } rsp_t;

  // Status of the scan engine toward the top level
  typedef struct packed {
    logic idle;
    logic done;
  } stat_t;

endpackage

// ===== rtl/core/bitmap_run_allocator_unit.sv =====
// Top level of the bitmap run allocator: request/response handshake, output
// register and the scan engine over the circulating occupancy map.
// Depends on bra_pkg, bra_map and bra_scan.

// First-fit allocator over a MAP_BITS-bit occupancy map (cleared at reset),
// walked eight bits per cycle as the map rotates through a single digit
// port. Free, find and query take one rotation of the map; an alloc that
// succeeds takes a second rotation, marking the run. The result is then
// handed to the output register once that register is free, and the
// engine passes through idle before it takes the next item. One item is
// worked at a time; a new item is taken while the previous result still
// waits in the output register. MAP_BITS must be a multiple of 8.
module bitmap_run_allocator_unit #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  bra_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output bra_pkg::rsp_t rsp
);

  logic                           accept;
  logic                           take;
  logic                           shift;
  logic [bra_pkg::DIGIT_BITS-1:0] map_digit;
  logic [bra_pkg::DIGIT_BITS-1:0] wr_digit;
  bra_pkg::stat_t                 stat;
  bra_pkg::rsp_t                  rsp_data;

  // Take an item only when the engine is free
  assign req_stall = !stat.idle;
  assign accept    = req_valid && !req_stall;
  assign take      = stat.done && (!rsp_valid || !rsp_stall);

  bra_map #(
    .MAP_BITS(MAP_BITS)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift),
    .wr_digit(wr_digit),
    .rd_digit(map_digit)
  );

  bra_scan #(
    .MAP_BITS(MAP_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .take     (take),
    .map_digit(map_digit),
    .wr_digit (wr_digit),
    .shift    (shift),
    .stat     (stat),
    .rsp_data (rsp_data)
  );

  // Output register: load a finished result, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_data;
    end
  end

  // An accepted item keeps the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !stat.idle)
    else $error("engine idle after accepting an item");

  // A handed-over result shows up at the output
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    take |=> rsp_valid)
    else $error("result lost on handover");

  // A failed command reports index zero and run length zero
  a_fail_index: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.success) |-> (rsp.bit_index == 8'd0 && rsp.run_length == 9'd0))
    else $error("failure with nonzero index or length");

  // Only a query reports a run length, and it always succeeds at index zero
  a_len_query: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.run_length != 9'd0) |-> (rsp.success && rsp.bit_index == 8'd0))
    else $error("run length on a non-query result");

endmodule

// ===== rtl/core/bra_map.sv =====
// Occupancy map held as a circulating shift register, one digit per cycle while shift is high.
// Depends on bra_pkg for the digit width.
module bra_map #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           shift,
  input  logic [bra_pkg::DIGIT_BITS-1:0] wr_digit,
  output logic [bra_pkg::DIGIT_BITS-1:0] rd_digit
);

  logic [MAP_BITS-1:0] map;

  // Present the low digit; write back the updated digit at the top on each step
  assign rd_digit = map[bra_pkg::DIGIT_BITS-1:0];

  if (MAP_BITS > bra_pkg::DIGIT_BITS) begin : g_wide
    always_ff @(posedge clk) begin
      if (rst) begin
        map <= '0;
      end else if (shift) begin
        map <= {wr_digit, map[MAP_BITS-1:bra_pkg::DIGIT_BITS]};
      end
    end
  end else begin : g_single
    always_ff @(posedge clk) begin
      if (rst) begin
        map <= '0;
      end else if (shift) begin
        map <= wr_digit;
      end
    end
  end

endmodule

// ===== rtl/core/bra_scan.sv =====
// Command sequencer: walks the circulating map one digit a cycle and
// carries run, search and range state between digits. Depends on bra_pkg.
module bra_scan #(
  parameter int MAP_BITS = bra_pkg::MAP_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  bra_pkg::req_t                  req,
  input  logic                           take,
  input  logic [bra_pkg::DIGIT_BITS-1:0] map_digit,
  output logic [bra_pkg::DIGIT_BITS-1:0] wr_digit,
  output logic                           shift,
  output bra_pkg::stat_t                 stat,
  output bra_pkg::rsp_t                  rsp_data
);

  localparam int DCNT = MAP_BITS / bra_pkg::DIGIT_BITS;
  localparam int DW   = (DCNT > 1) ? $clog2(DCNT) : 1;
  localparam int IW   = $clog2(MAP_BITS);
  localparam int RW   = $clog2(MAP_BITS + 1);
  localparam int XW   = ((IW > 9) ? IW : 9) + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_MARK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t        state;
  logic [1:0]    cmd;
  logic [7:0]    start;
  logic [8:0]    count;
  logic          value;
  logic [DW-1:0] dig;
  logic [RW-1:0] run;
  logic [RW-1:0] run_start;
  logic [RW-1:0] best;
  logic [RW-1:0] hit;
  logic          found;

  logic [RW-1:0] run_next;
  logic [RW-1:0] run_start_next;
  logic [RW-1:0] best_next;
  logic [RW-1:0] hit_next;
  logic          found_next;
  bra_pkg::rsp_t res_next;
  logic          last;

  assign last  = (dig == DW'(DCNT - 1));
  assign shift = (state == S_SCAN) || (state == S_MARK);
  assign stat.idle = (state == S_IDLE);
  assign stat.done = (state == S_DONE);

  // Process the eight bits of the current digit in index order
  always_comb begin
    logic [XW-1:0] pos;
    logic [XW-1:0] start_x;
    logic [XW-1:0] end_x;
    logic [XW-1:0] best_x;
    logic          b;
    run_next       = run;
    run_start_next = run_start;
    best_next      = best;
    hit_next       = hit;
    found_next     = found;
    wr_digit       = map_digit;
    start_x        = XW'(start);
    end_x          = XW'(start) + XW'(count);
    for (int j = 0; j < bra_pkg::DIGIT_BITS; j++) begin
      pos = (XW'(dig) << bra_pkg::DIGIT_LOG) | XW'(j);
      b   = map_digit[j];
      if (state == S_MARK) begin
        if ((pos >= XW'(run_start)) && (pos <= XW'(hit))) begin
          wr_digit[j] = 1'b1;
        end
      end else if (state == S_SCAN) begin
        case (cmd)
          bra_pkg::CMD_ALLOC: begin
            if (!found_next) begin
              if (!b) begin
                run_next = run_next + RW'(1);
                if (XW'(run_next) == XW'(count)) begin
                  found_next = 1'b1;
                  hit_next   = RW'(pos);
                end
              end else begin
                run_next       = '0;
                run_start_next = RW'(pos + XW'(1));
              end
            end
          end
          bra_pkg::CMD_FREE: begin
            if ((pos >= start_x) && (pos < end_x)) begin
              wr_digit[j] = 1'b0;
            end
          end
          bra_pkg::CMD_FIND: begin
            if (!found_next && (pos >= start_x) && (b == value)) begin
              found_next = 1'b1;
              hit_next   = RW'(pos);
            end
          end
          default: begin
            if (!b) begin
              run_next = run_next + RW'(1);
              if (run_next > best_next) begin
                best_next = run_next;
              end
            end else begin
              run_next = '0;
            end
          end
        endcase
      end
    end

    // Form the result from the state left after the last digit
    best_x              = XW'(best_next);
    res_next.success    = 1'b1;
    res_next.bit_index  = '0;
    res_next.run_length = '0;
    case (cmd)
      bra_pkg::CMD_ALLOC: begin
        res_next.success = found_next;
        if (found_next) begin
          res_next.bit_index = 8'(XW'(run_start_next));
        end
      end
      bra_pkg::CMD_FREE: begin
        res_next.success = 1'b1;
      end
      bra_pkg::CMD_FIND: begin
        res_next.success = found_next;
        if (found_next) begin
          res_next.bit_index = 8'(XW'(hit_next));
        end
      end
      default: begin
        if (best_x > XW'(bra_pkg::RUN_LEN_MAX)) begin
          res_next.run_length = bra_pkg::RUN_LEN_MAX;
        end else begin
          res_next.run_length = 9'(best_x);
        end
      end
    endcase
  end

  // Sequence: one full rotation per pass, a second rotation to mark a successful alloc
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dig   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
            dig   <= '0;
          end
        end
        S_SCAN: begin
          dig <= last ? '0 : dig + DW'(1);
          if (last) begin
            if ((cmd == bra_pkg::CMD_ALLOC) && found_next) begin
              state <= S_MARK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_MARK: begin
          dig <= last ? '0 : dig + DW'(1);
          if (last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the command and the per-item scan state
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && accept) begin
      cmd       <= req.command;
      start     <= req.start_index;
      count     <= req.run_count;
      value     <= req.find_value;
      run       <= '0;
      run_start <= '0;
      best      <= '0;
      hit       <= '0;
      found     <= 1'b0;
    end else if (state == S_SCAN) begin
      run       <= run_next;
      run_start <= run_start_next;
      best      <= best_next;
      hit       <= hit_next;
      found     <= found_next;
    end
    if (((state == S_SCAN) || (state == S_MARK)) && last) begin
      rsp_data <= res_next;
    end
  end

endmodule
